@@ design/lcdb_pkg.sv @@
package lcdb_pkg;

	// code point and table entry layout
	localparam int CP_W        = 21;
	localparam int ENTRY_W     = 22;
	localparam int ENTRY_VALID = 21;
	localparam int CFG_DATA_W  = 44;
	localparam int CFG_INDEX_W = 3;
	localparam int BYTE_W      = 8;

	localparam int TABLE_ENTRIES_DEF = 8;
	localparam int TABLE_ENTRIES_MAX = 8;

	// configuration register indexes
	localparam logic [CFG_INDEX_W-1:0] CFG_NIBBLE_MODE = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_CODES_01    = 3'd1;

	// byte classes
	localparam logic [BYTE_W-1:0] ASCII_MAX = 8'h7F;
	localparam logic [BYTE_W-1:0] LEAD2_MAX = 8'hDF;
	localparam logic [BYTE_W-1:0] LEAD3_MAX = 8'hEF;

	// one bus write request passed from decoder to bus side
	typedef struct packed {
		logic [BYTE_W-1:0] value;
		logic              not_found;
	} job_t;

endpackage

@@ design/lcdb_front.sv @@
module lcdb_front #(
	parameter int TABLE_ENTRIES = lcdb_pkg::TABLE_ENTRIES_DEF
) (
	input  logic                                           clk,
	input  logic                                           arst_n,
	input  logic                                           s_tvalid,
	output logic                                           s_tready,
	input  logic [lcdb_pkg::BYTE_W-1:0]                    s_tdata, // text_byte
	input  logic                                           s_tlast, // end_of_text
	input  logic [TABLE_ENTRIES-1:0][lcdb_pkg::ENTRY_W-1:0] table_entries,
	input  logic                                           queue_full,
	output logic                                           push,
	output lcdb_pkg::job_t                                 push_job
);
	import lcdb_pkg::*;

	localparam int IdxW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

	logic [1:0]      pend_q, pend_n;
	logic [CP_W-1:0] acc_q, acc_n, acc_done;
	logic            skip_q, skip_n;
	logic            accept;
	logic            job_valid;
	job_t            job;
	logic            hit;
	logic [IdxW-1:0] hit_idx;
	logic [BYTE_W-1:0] b;

	assign b        = s_tdata;
	assign s_tready = !queue_full;
	assign accept   = s_tvalid && s_tready;

	// merge continuation bits into the code point
	always_comb begin
		case (pend_q - 2'd1)
			2'd2:    acc_done = acc_q | {3'b0, b[5:0], 12'b0};
			2'd1:    acc_done = acc_q | {9'b0, b[5:0], 6'b0};
			default: acc_done = acc_q | {15'b0, b[5:0]};
		endcase
	end

	// custom table search, lowest index wins
	always_comb begin
		hit     = 1'b0;
		hit_idx = '0;
		for (int e = TABLE_ENTRIES - 1; e >= 0; e--) begin
			if (table_entries[e][ENTRY_VALID] && table_entries[e][CP_W-1:0] == acc_done) begin
				hit     = 1'b1;
				hit_idx = IdxW'(e);
			end
		end
	end

	// byte classification and state update
	always_comb begin
		pend_n    = pend_q;
		acc_n     = acc_q;
		skip_n    = skip_q;
		job_valid = 1'b0;
		job.value     = b;
		job.not_found = 1'b0;
		if (skip_q) begin
			// skipping until end of text
		end else if (pend_q == 2'd0) begin
			if (b <= ASCII_MAX) begin
				job_valid = 1'b1;
			end else if (b <= LEAD2_MAX) begin
				acc_n  = {10'b0, b[4:0], 6'b0};
				pend_n = 2'd1;
			end else if (b <= LEAD3_MAX) begin
				acc_n  = {5'b0, b[3:0], 12'b0};
				pend_n = 2'd2;
			end else begin
				acc_n  = {b[2:0], 18'b0};
				pend_n = 2'd3;
			end
		end else begin
			pend_n = pend_q - 2'd1;
			acc_n  = acc_done;
			if (pend_n == 2'd0) begin
				acc_n     = '0;
				job_valid = 1'b1;
				if (hit) begin
					job.value = BYTE_W'(hit_idx);
				end else begin
					job.value     = '0;
					job.not_found = 1'b1;
					skip_n        = 1'b1;
				end
			end
		end
		if (s_tlast) begin
			pend_n = 2'd0;
			acc_n  = '0;
			skip_n = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= 2'd0;
			acc_q  <= '0;
			skip_q <= 1'b0;
		end else if (accept) begin
			pend_q <= pend_n;
			acc_q  <= acc_n;
			skip_q <= skip_n;
		end
	end

	assign push     = accept && job_valid;
	assign push_job = job;

	// skip only follows a finished sequence
	a_skip_idle: assert property (@(posedge clk) disable iff (!arst_n)
		skip_q |-> pend_q == 2'd0) else $error("skip set with sequence open");

	// accumulator is clear between sequences
	a_acc_clear: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q == 2'd0 |-> acc_q == '0) else $error("stale code point");

	// a lookup miss enters skip unless text ends
	a_miss_skip: assert property (@(posedge clk) disable iff (!arst_n)
		push && push_job.not_found && !s_tlast |=> skip_q) else $error("miss without skip");

endmodule

@@ design/lcdb_queue.sv @@
module lcdb_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  lcdb_pkg::job_t push_job,
	output logic           full,
	input  logic           pop,
	output logic           head_valid,
	output lcdb_pkg::job_t head_job
);
	import lcdb_pkg::*;

	job_t       slot_q [2];
	logic       wr_q, rd_q;
	logic [1:0] count_q;

	assign full       = count_q == 2'd2;
	assign head_valid = count_q != 2'd0;
	assign head_job   = slot_q[rd_q];

	// payload slots
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= push_job;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= 1'b0;
			rd_q    <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= !wr_q;
			end
			if (pop) begin
				rd_q <= !rd_q;
			end
			count_q <= count_q + {1'b0, push} - {1'b0, pop};
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !push) else $error("push into full queue");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		!head_valid |-> !pop) else $error("pop from empty queue");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q != 2'd3) else $error("queue count out of range");

endmodule

@@ design/lcdb_back.sv @@
module lcdb_back (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       nibble_mode,
	input  logic                       head_valid,
	input  lcdb_pkg::job_t             head_job,
	output logic                       pop,
	output logic                       m_tvalid,
	input  logic                       m_tready,
	output logic [lcdb_pkg::BYTE_W-1:0] m_tdata, // bus_value
	output logic                       m_tuser, // char_not_found
	output logic                       m_tlast  // last_transfer
);
	import lcdb_pkg::*;

	logic              phase_q;
	logic              load;
	logic              last;
	logic              valid_q;
	logic [BYTE_W-1:0] data_q;
	logic              user_q, last_q;

	// a transfer is loaded whenever the output register is free
	assign load = head_valid && (!valid_q || m_tready);
	assign last = head_job.not_found || !nibble_mode || phase_q;
	assign pop  = load && last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= 1'b0;
			valid_q <= 1'b0;
		end else begin
			if (load) begin
				phase_q <= !last;
			end
			if (load) begin
				valid_q <= 1'b1;
			end else if (m_tready) begin
				valid_q <= 1'b0;
			end
		end
	end

	// output payload: high nibble half first, then low nibble moved up
	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= phase_q ? {head_job.value[3:0], 4'b0} : head_job.value;
			user_q <= head_job.not_found;
			last_q <= last;
		end
	end

	assign m_tvalid = valid_q;
	assign m_tdata  = data_q;
	assign m_tuser  = user_q;
	assign m_tlast  = last_q;

	// second half only while its request is still queued
	a_phase_head: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q |-> head_valid) else $error("second transfer without request");

	// a miss never takes the two-transfer path
	a_phase_found: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q |-> !head_job.not_found) else $error("split miss result");

	// miss result is a single zero transfer
	a_miss_form: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata == '0 && m_tlast) else $error("bad miss result");

endmodule

@@ design/utf8_text_to_lcd_bus_top.sv @@
// UTF-8 text to character LCD data bus. Text bytes come in on the s_ stream,
// one per request, with tlast on the final byte of a string; data-bus writes
// go out on the m_ stream. ASCII bytes are written as they are; a multi-byte
// sequence is decoded and its code point looked up in the custom character
// table (written through the cfg port), and the index of the first valid
// matching entry is written. A code point not in the table gives one result
// with tuser set and then the rest of the string is skipped. In 4-bit bus mode
// each written byte becomes two transfers, the byte and then the byte shifted
// left by four. The decoder takes one byte per cycle while the queue has room
// and hands writes through a two-entry queue to the bus side, whose output
// register gives one transfer per cycle while the receiver is ready; lead and
// middle bytes of a sequence give no transfer. Configuration must be written
// only while the block is idle; the block itself does not enforce it.
module utf8_text_to_lcd_bus_top #(
	parameter int TABLE_ENTRIES = lcdb_pkg::TABLE_ENTRIES_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [lcdb_pkg::BYTE_W-1:0]     s_tdata, // text_byte
	input  logic                            s_tlast, // end_of_text
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [lcdb_pkg::BYTE_W-1:0]     m_tdata, // bus_value
	output logic                            m_tuser, // char_not_found
	output logic                            m_tlast, // last_transfer
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [lcdb_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [lcdb_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import lcdb_pkg::*;

	logic                                  nibble_q;
	logic [TABLE_ENTRIES-1:0][ENTRY_W-1:0] entry_q;
	logic                                  cfg_wr;
	logic                                  push, pop, full, head_valid;
	job_t                                  push_job, head_job;

	assign cfg_ready = 1'b1;
	assign cfg_wr    = cfg_valid && cfg_ready;

	// configuration registers, two table entries per code register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nibble_q <= 1'b0;
			entry_q  <= '0;
		end else if (cfg_wr) begin
			if (cfg_index == CFG_NIBBLE_MODE) begin
				nibble_q <= cfg_data[0];
			end
			for (int e = 0; e < TABLE_ENTRIES; e++) begin
				if (cfg_index == CFG_CODES_01 + CFG_INDEX_W'(e / 2)) begin
					entry_q[e] <= cfg_data[(e % 2) * ENTRY_W +: ENTRY_W];
				end
			end
		end
	end

	lcdb_front #(
		.TABLE_ENTRIES(TABLE_ENTRIES)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_tvalid     (s_tvalid),
		.s_tready     (s_tready),
		.s_tdata      (s_tdata),
		.s_tlast      (s_tlast),
		.table_entries(entry_q),
		.queue_full   (full),
		.push         (push),
		.push_job     (push_job)
	);

	lcdb_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_job  (push_job),
		.full      (full),
		.pop       (pop),
		.head_valid(head_valid),
		.head_job  (head_job)
	);

	lcdb_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.nibble_mode(nibble_q),
		.head_valid (head_valid),
		.head_job   (head_job),
		.pop        (pop),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser),
		.m_tlast    (m_tlast)
	);

endmodule

@@ verif/utf8_text_to_lcd_bus_checker.sv @@
module utf8_text_to_lcd_bus_checker #(
	parameter int TABLE_ENTRIES = lcdb_pkg::TABLE_ENTRIES_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	input  logic                             s_tready,
	input  logic [lcdb_pkg::BYTE_W-1:0]      s_tdata, // text_byte
	input  logic                             s_tlast, // end_of_text
	input  logic                             m_tvalid,
	input  logic                             m_tready,
	input  logic [lcdb_pkg::BYTE_W-1:0]      m_tdata, // bus_value
	input  logic                             m_tuser, // char_not_found
	input  logic                             m_tlast, // last_transfer
	input  logic                             cfg_valid,
	input  logic                             cfg_ready,
	input  logic [lcdb_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [lcdb_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                             end_check,
	output int                               fail_count,
	output int                               writes_pending,
	output int                               bytes_decoded
);
	timeunit 1ns;
	timeprecision 1ps;

	import lcdb_pkg::*;

	// one data-bus write as it should leave the block
	typedef struct packed {
		logic [BYTE_W-1:0] value;
		logic              not_found;
		logic              last;
	} lcd_write_t;

	lcd_write_t lcd_writes[$];

	// own copy of the settings and the decoder state
	logic                  nibble_mode = 1'b0;
	logic [CFG_DATA_W-1:0] code_regs [4] = '{default: '0};
	logic [1:0]            cont_left = '0;
	logic [CP_W-1:0]       code_acc = '0;
	logic                  skipping = 1'b0;
	bit                    end_done = 1'b0;

	task automatic report_mismatch(input string what);
		fail_count++;
		$display("[%0t] lcd bus mismatch: %s", $time, what);
	endtask

	// first valid entry holding the code point, lowest index first
	function automatic int find_custom_char(input logic [CP_W-1:0] cp);
		logic [ENTRY_W-1:0] entry;
		for (int i = 0; i < TABLE_ENTRIES && i < TABLE_ENTRIES_MAX; i++) begin
			entry = code_regs[i / 2][(i % 2) * ENTRY_W +: ENTRY_W];
			if (entry[ENTRY_VALID] && entry[CP_W-1:0] == cp)
				return i;
		end
		return -1;
	endfunction

	// one transfer on the 8-bit bus, two on the 4-bit bus
	function automatic void queue_char(input logic [BYTE_W-1:0] value);
		logic [BYTE_W-1:0] shifted;
		shifted = value << 4;
		if (nibble_mode) begin
			lcd_writes.push_back('{value, 1'b0, 1'b0});
			lcd_writes.push_back('{shifted, 1'b0, 1'b1});
		end else begin
			lcd_writes.push_back('{value, 1'b0, 1'b1});
		end
	endfunction

	function automatic void decode_text_byte(input logic [BYTE_W-1:0] b, input logic eot);
		int idx;
		// every accepted byte counts, skipped ones too
		bytes_decoded++;
		if (!skipping) begin
			if (cont_left == 2'd0) begin
				// plain character or lead byte
				if (b <= ASCII_MAX) begin
					queue_char(b);
				end else if (b <= LEAD2_MAX) begin
					code_acc  = CP_W'(b[4:0]) << 6;
					cont_left = 2'd1;
				end else if (b <= LEAD3_MAX) begin
					code_acc  = CP_W'(b[3:0]) << 12;
					cont_left = 2'd2;
				end else begin
					code_acc  = CP_W'(b[2:0]) << 18;
					cont_left = 2'd3;
				end
			end else begin
				// continuation byte, low six bits only
				cont_left = cont_left - 2'd1;
				code_acc  = code_acc | (CP_W'(b[5:0]) << (6 * cont_left));
				if (cont_left == 2'd0) begin
					idx      = find_custom_char(code_acc);
					code_acc = '0;
					if (idx >= 0) begin
						queue_char(BYTE_W'(idx));
					end else begin
						lcd_writes.push_back('{'0, 1'b1, 1'b1});
						skipping = 1'b1;
					end
				end
			end
		end
		// end of text drops any partial sequence and the skip
		if (eot) begin
			cont_left = '0;
			code_acc  = '0;
			skipping  = 1'b0;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		lcd_write_t want;
		if (!arst_n) begin
			nibble_mode = 1'b0;
			code_regs   = '{default: '0};
			cont_left   = '0;
			code_acc    = '0;
			skipping    = 1'b0;
			lcd_writes.delete();
		end else begin
			// register write request
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == CFG_NIBBLE_MODE)
					nibble_mode = cfg_data[0];
				else if (cfg_index >= CFG_CODES_01 && cfg_index <= CFG_CODES_01 + 3'd3)
					code_regs[cfg_index - CFG_CODES_01] = cfg_data;
			end

			// bus write leaving the block
			if (m_tvalid && m_tready) begin
				if (lcd_writes.size() == 0) begin
					report_mismatch($sformatf("unexpected write %02h tuser %b tlast %b",
						m_tdata, m_tuser, m_tlast));
				end else begin
					want = lcd_writes.pop_front();
					if (m_tdata !== want.value)
						report_mismatch($sformatf("bus value %02h, wanted %02h",
							m_tdata, want.value));
					if (m_tuser !== want.not_found)
						report_mismatch($sformatf("not-found flag %b, wanted %b (value %02h)",
							m_tuser, want.not_found, want.value));
					if (m_tlast !== want.last)
						report_mismatch($sformatf("last flag %b, wanted %b (value %02h)",
							m_tlast, want.last, want.value));
				end
			end

			// text byte request
			if (s_tvalid && s_tready)
				decode_text_byte(s_tdata, s_tlast);

			// anything still queued at the end never arrived
			if (end_check && !end_done) begin
				end_done = 1'b1;
				if (lcd_writes.size() != 0)
					report_mismatch($sformatf("%0d bus writes never arrived",
						lcd_writes.size()));
			end

			writes_pending = lcd_writes.size();
		end
	end

endmodule

@@ verif/utf8_text_to_lcd_bus_top_tb.sv @@
module utf8_text_to_lcd_bus_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import lcdb_pkg::*;

	localparam int CLK_HALF        = 6;
	localparam int RESET_CYCLES    = 8;
	localparam int CYCLE_LIMIT     = 2_000_000;
	localparam int HOLD_OFF_CYCLES = 400;
	localparam int SETTLE_CYCLES   = 16;
	localparam int PHASE_QUOTA [6] = '{350, 350, 150, 150, 450, 450};

	// indexes past the register list, writes there are dropped
	localparam logic [CFG_INDEX_W-1:0] CFG_NONE_FIRST = CFG_CODES_01 + 3'd4;

	// {end_of_text, text_byte}: ascii extremes, unmatched code point, skip
	localparam logic [8:0] OPENING_TEXT [5] = '{9'h000, 9'h07F, 9'h0C0, 9'h080, 9'h141};
	// longest code point, lead 0x80, miss cut by end of text, 3- and 4-byte
	// leads at both ends, invalid entry passed over, lead cut by end of text
	localparam logic [8:0] TABLE_TEXT [21] = '{
		9'h0FF, 9'h0BF, 9'h0BF, 9'h0BF,
		9'h080, 9'h080,
		9'h0DF, 9'h1BF,
		9'h0E0, 9'h0A0, 9'h080,
		9'h0EF, 9'h0BF, 9'h0BF,
		9'h0F0, 9'h090, 9'h080, 9'h080,
		9'h0C1, 9'h081,
		9'h1E2
	};

	logic                   clk = 1'b0;
	logic                   arst_n;
	logic                   s_tvalid;
	logic                   s_tready;
	logic [BYTE_W-1:0]      s_tdata;
	logic                   s_tlast;
	logic                   m_tvalid;
	logic                   m_tready;
	logic [BYTE_W-1:0]      m_tdata;
	logic                   m_tuser;
	logic                   m_tlast;
	logic                   cfg_valid;
	logic                   cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_data;
	logic                   end_check;
	logic                   hold_go;
	bit                     hold_done = 1'b0;
	bit                     tx_gapless = 1'b0;
	int                     fail_count;
	int                     writes_pending;
	int                     bytes_decoded;
	int unsigned            cycle_count = 0;

	// table and bus mode of the current phase
	logic [CP_W-1:0] entry_cp [8];
	logic            entry_ok [8];
	logic            nibble;

	utf8_text_to_lcd_bus_top i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	utf8_text_to_lcd_bus_checker i_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.s_tvalid       (s_tvalid),
		.s_tready       (s_tready),
		.s_tdata        (s_tdata),
		.s_tlast        (s_tlast),
		.m_tvalid       (m_tvalid),
		.m_tready       (m_tready),
		.m_tdata        (m_tdata),
		.m_tuser        (m_tuser),
		.m_tlast        (m_tlast),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.end_check      (end_check),
		.fail_count     (fail_count),
		.writes_pending (writes_pending),
		.bytes_decoded  (bytes_decoded)
	);

	always #(CLK_HALF) clk = ~clk;

	// run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	// mostly short gaps, now and then a long one
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// receiver: random stalls, clear stretches and one long hold-off
	initial begin
		int stretch;
		m_tready <= 1'b0;
		@(posedge arst_n);
		forever begin
			if (hold_go && !hold_done) begin
				m_tready <= 1'b0;
				repeat (HOLD_OFF_CYCLES) @(posedge clk);
				hold_done = 1'b1;
			end else if ($urandom_range(0, 4) == 0) begin
				m_tready <= 1'b1;
				repeat ($urandom_range(10, 60)) @(posedge clk);
			end else begin
				stretch = pick_gap();
				if (stretch > 0) begin
					m_tready <= 1'b0;
					repeat (stretch) @(posedge clk);
				end
				m_tready <= 1'b1;
				repeat ($urandom_range(1, 4)) @(posedge clk);
			end
		end
	end

	task automatic push_text_byte(input logic [BYTE_W-1:0] b, input logic eot);
		int gap;
		gap = tx_gapless ? 0 : pick_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		s_tlast  <= eot;
		do @(posedge clk); while (!s_tready);
	endtask

	// valid stays up across a series, the caller lowers it
	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
		input logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
	endtask

	task automatic load_settings();
		logic [CFG_DATA_W-1:0] pair;
		for (int k = 0; k < 4; k++) begin
			pair = {entry_ok[2*k+1], entry_cp[2*k+1], entry_ok[2*k], entry_cp[2*k]};
			write_reg(CFG_CODES_01 + 3'(k), pair);
		end
		// unused upper bits carry noise
		write_reg(CFG_NIBBLE_MODE, {11'($urandom), 32'($urandom), nibble});
		cfg_valid <= 1'b0;
	endtask

	// stop sending, let every write drain and the decoder settle
	task automatic wait_idle();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (writes_pending != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic logic [CP_W-1:0] rand_code_point();
		int r;
		r = $urandom_range(0, 9);
		if (r < 4)
			return CP_W'($urandom_range(0, 'h7FF));
		if (r < 7)
			return CP_W'($urandom_range('h800, 'hFFFF));
		return CP_W'($urandom);
	endfunction

	// shortest encoding that holds the code point, or a longer one
	function automatic int pick_length(input logic [CP_W-1:0] cp);
		if (cp <= 'h7FF)
			return $urandom_range(2, 4);
		if (cp <= 'hFFFF)
			return $urandom_range(3, 4);
		return 4;
	endfunction

	task automatic randomise_table();
		for (int i = 0; i < 8; i++) begin
			if (i > 0 && $urandom_range(0, 9) == 0)
				entry_cp[i] = entry_cp[$urandom_range(0, i - 1)];
			else
				entry_cp[i] = rand_code_point();
			entry_ok[i] = ($urandom_range(0, 99) < 85);
		end
	endtask

	// encode a code point, sending only the first keep bytes
	task automatic send_code_point(input logic [CP_W-1:0] cp, input int len,
		input int keep, input bit eot);
		logic [BYTE_W-1:0] seq [4];
		case (len)
			2: seq[0] = {3'($urandom_range(4, 6)), cp[10:6]};
			3: seq[0] = {4'hE, cp[15:12]};
			default: seq[0] = {4'hF, 1'($urandom), cp[20:18]};
		endcase
		// top bits of a continuation byte are not checked by the block
		for (int k = 1; k < len; k++)
			seq[k] = {2'($urandom), cp[6*(len-1-k) +: 6]};
		for (int k = 0; k < keep; k++)
			push_text_byte(seq[k], eot && k == keep - 1);
	endtask

	// one string: mostly table hits, some ascii, misses, noise and cut sequences
	task automatic send_text_string();
		int units;
		int kind;
		int len;
		bit tail;
		logic [CP_W-1:0] cp;
		units      = $urandom_range(1, 10);
		tx_gapless = ($urandom_range(0, 4) == 0);
		for (int u = 0; u < units; u++) begin
			tail = (u == units - 1);
			kind = $urandom_range(0, 99);
			cp   = (kind < 55 || kind >= 91) ? entry_cp[$urandom_range(0, 7)]
			                                 : rand_code_point();
			len  = pick_length(cp);
			if (kind < 55)
				send_code_point(cp, len, len, tail);
			else if (kind < 75)
				push_text_byte(BYTE_W'($urandom_range(0, 127)), tail);
			else if (kind < 83)
				send_code_point(cp, len, len, tail);
			else if (kind < 91)
				push_text_byte(BYTE_W'($urandom), tail);
			else
				send_code_point(cp, len, $urandom_range(1, len - 1),
					tail || $urandom_range(0, 1));
		end
	endtask

	task automatic run_phase(input int quota);
		int start;
		start = bytes_decoded;
		while (bytes_decoded - start < quota)
			send_text_string();
		wait_idle();
	endtask

	initial begin
		arst_n    <= 1'b0;
		s_tvalid  <= 1'b0;
		s_tdata   <= '0;
		s_tlast   <= 1'b0;
		cfg_valid <= 1'b0;
		cfg_index <= CFG_NIBBLE_MODE;
		cfg_data  <= '0;
		end_check <= 1'b0;
		hold_go   <= 1'b0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: empty table, 8-bit bus
		foreach (OPENING_TEXT[k])
			push_text_byte(OPENING_TEXT[k][7:0], OPENING_TEXT[k][8]);
		wait_idle();

		// hand-picked table on the 4-bit bus, duplicate and invalid entries
		entry_cp = '{21'h1FFFFF, 21'h0, 21'h41, 21'h41, 21'h41, 21'h800, 21'hFFFF, 21'h10000};
		entry_ok = '{1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1};
		nibble   = 1'b1;
		for (int k = 0; k < 3; k++)
			write_reg(CFG_NONE_FIRST + 3'(k), {12'($urandom), 32'($urandom)});
		load_settings();
		foreach (TABLE_TEXT[k])
			push_text_byte(TABLE_TEXT[k][7:0], TABLE_TEXT[k][8]);
		wait_idle();

		// random text under several settings, extremes among them
		for (int p = 0; p < 6; p++) begin
			case (p)
				2: begin
					for (int i = 0; i < 8; i++) begin
						entry_cp[i] = '1;
						entry_ok[i] = 1'b1;
					end
					nibble = 1'b0;
				end
				3: begin
					for (int i = 0; i < 8; i++) begin
						entry_cp[i] = '0;
						entry_ok[i] = 1'b0;
					end
					nibble = 1'b1;
				end
				default: begin
					randomise_table();
					nibble = (p == 1) ? 1'b1 : (p == 0) ? 1'b0 : 1'($urandom);
				end
			endcase
			load_settings();
			// receiver holds off while text keeps coming
			if (p == 1)
				hold_go <= 1'b1;
			run_phase(PHASE_QUOTA[p]);
		end

		end_check <= 1'b1;
		repeat (2) @(posedge clk);
		if (fail_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
